[hdl/bc13_pkg.sv]
// Shared types and arithmetic helpers for the BC1/BC3 block decoder.
// Used by bc13_table and by the top level bc1_bc3_block_decoder.
// No dependencies.
package bc13_pkg;

  // Field widths of the stream payloads
  localparam int unsigned HalfW     = 64;
  localparam int unsigned BlockW    = 10;
  localparam int unsigned CoordW    = 12;
  localparam int unsigned InDataW   = 152;  // 148 payload bits, padded to 19 bytes
  localparam int unsigned OutDataW  = 56;
  localparam int unsigned PixCount  = 16;
  localparam int unsigned RecipShift = 24;  // fraction bits of the coordinate reciprocal

  // Per-block lookup tables: four RGB palette entries and eight alpha values.
  // rgb[entry][0] is red, [1] green, [2] blue.
  typedef struct packed {
    logic [3:0][2:0][7:0] rgb;
    logic [7:0][7:0]      alpha;
  } bc13_tab_t;

  // 5-bit and 6-bit channel expansion by bit replication
  function automatic logic [7:0] expand5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] c);
    return {c, c[5:4]};
  endfunction

  // floor(v/3) for v <= 765: multiply by 683/2048
  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [20:0] p;
    p = 21'(v) * 21'd683;
    return p[18:11];
  endfunction

  // floor(v/5) for v <= 1275: multiply by 3277/16384
  function automatic logic [7:0] div5(input logic [10:0] v);
    logic [22:0] p;
    p = 23'(v) * 23'd3277;
    return p[21:14];
  endfunction

  // floor(v/7) for v <= 1785: multiply by 2341/16384
  function automatic logic [7:0] div7(input logic [10:0] v);
    logic [22:0] p;
    p = 23'(v) * 23'd2341;
    return p[21:14];
  endfunction

endpackage

[hdl/bc1_bc3_block_decoder.sv]
// Top level of the BC1/BC3 texture block decoder.
// Depends on bc13_pkg and instantiates bc13_table.
//
// Usage:
//   The s_ stream takes one compressed 4x4 block per transaction. The m_
//   stream returns the sixteen decoded RGBA pixels of that block in
//   row-major order with their image coordinates; m_tlast marks the
//   sixteenth pixel. The cfg channel writes format_bc3 (0 = BC1, 1 = BC3);
//   it is always ready and must only be written while the block is idle.
// Path: the first pixel passes the input, table and output registers
//   before it appears on m_tvalid. Throughput: one pixel per cycle while
//   m_tready is high, set by the single output register pixels exit.
//   Three blocks can be in flight: the input register, the table register
//   that feeds the pixel counter, and the output register.
// Reset: rst (synchronous) empties all stages and selects BC1.
// Stall: while m_tready is low the current pixel holds in the output
//   register, the pixel counter stops, and s_tready drops once the input
//   register is full behind the block being emitted.
module bc1_bc3_block_decoder #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_data,   // format_bc3
  // block input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // s_tdata from bit 0: alpha_half[63:0], colour_half[63:0],
  // block_col[9:0], block_row[9:0], 4 zero pad bits
  input  logic [bc13_pkg::InDataW-1:0]   s_tdata,
  // pixel output stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // m_tdata from bit 0: red[7:0], green[7:0], blue[7:0], alpha[7:0],
  // pixel_x[11:0], pixel_y[11:0]
  output logic [bc13_pkg::OutDataW-1:0]  m_tdata,
  output logic                           m_tlast
);

  // Coordinate reduction modulo MAX_DIM: q = floor(x * RECIP / 2^24).
  // Sizes at or above 4096 never wrap a 12-bit coordinate.
  localparam int unsigned DimW   = 15;
  localparam logic [DimW-1:0] DIM = DimW'(MAX_DIM);
  localparam int unsigned RecipW = 25;
  localparam logic [RecipW-1:0] RECIP = (MAX_DIM >= 4096) ? '0 :
      RecipW'(((64'd1 << bc13_pkg::RecipShift) + 64'(MAX_DIM) - 64'd1) / 64'(MAX_DIM));
  localparam int unsigned ProdW  = bc13_pkg::CoordW + RecipW;

  localparam int unsigned CW = bc13_pkg::CoordW;

  // Configuration register
  logic format_bc3;

  // Input register
  logic                       a_valid;
  logic [63:0]                a_alpha_half;
  logic [63:0]                a_colour_half;
  logic [bc13_pkg::BlockW-1:0] a_block_col;
  logic [bc13_pkg::BlockW-1:0] a_block_row;

  // Table register
  logic                b_valid;
  bc13_pkg::bc13_tab_t b_tab;
  logic [31:0]         b_cidx;
  logic [47:0]         b_aidx;
  logic [CW-1:0]       b_x;
  logic [CW-1:0]       b_y;
  logic [CW-1:0]       b_qx;
  logic [CW-1:0]       b_qy;
  logic [3:0]          cnt;

  // Handshake and flow control
  logic in_fire;
  logic out_free;
  logic emit;
  logic b_done;
  logic a_move;

  // Combinational values
  bc13_pkg::bc13_tab_t tab_new;
  logic [CW-1:0]       x_new;
  logic [CW-1:0]       y_new;
  logic [ProdW-1:0]    qx_prod;
  logic [ProdW-1:0]    qy_prod;
  logic [1:0]          ci;
  logic [2:0]          ai;
  logic [CW+DimW-1:0]  mx_prod;
  logic [CW+DimW-1:0]  my_prod;
  logic [CW-1:0]       base_x;
  logic [CW-1:0]       base_y;
  logic [DimW-1:0]     sum_x;
  logic [DimW-1:0]     sum_y;
  logic [DimW-1:0]     pix_x;
  logic [DimW-1:0]     pix_y;

  assign cfg_ready = 1'b1;

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign emit     = b_valid && out_free;
  assign b_done   = emit && (cnt == 4'(bc13_pkg::PixCount - 1));
  assign a_move   = a_valid && (!b_valid || b_done);
  assign s_tready = !a_valid || a_move;

  // Configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      format_bc3 <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      format_bc3 <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_fire) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_alpha_half  <= s_tdata[63:0];
      a_colour_half <= s_tdata[127:64];
      a_block_col   <= s_tdata[137:128];
      a_block_row   <= s_tdata[147:138];
    end
  end

  // Palette and alpha table of the block in the input register
  bc13_table u_table (
    .format_bc3  (format_bc3),
    .colour_ends (a_colour_half[31:0]),
    .alpha_ends  (a_alpha_half[15:0]),
    .tab         (tab_new)
  );

  // Block origin and its quotient by MAX_DIM
  assign x_new   = {a_block_col, 2'b00};
  assign y_new   = {a_block_row, 2'b00};
  assign qx_prod = ProdW'(x_new) * ProdW'(RECIP);
  assign qy_prod = ProdW'(y_new) * ProdW'(RECIP);

  // Table register
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_move) begin
      b_valid <= 1'b1;
    end else if (b_done) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_tab  <= tab_new;
      b_cidx <= a_colour_half[63:32];
      b_aidx <= a_alpha_half[63:16];
      b_x    <= x_new;
      b_y    <= y_new;
      b_qx   <= qx_prod[bc13_pkg::RecipShift +: CW];
      b_qy   <= qy_prod[bc13_pkg::RecipShift +: CW];
    end
  end

  // Pixel counter, wraps to zero at the end of each block
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (emit) begin
      cnt <= cnt + 4'd1;
    end
  end

  // Pixel select and coordinate wrap
  always_comb begin
    ci      = b_cidx[{cnt, 1'b0} +: 2];
    ai      = b_aidx[6'(cnt) * 6'd3 +: 3];
    mx_prod = (CW+DimW)'(b_qx) * (CW+DimW)'(DIM);
    my_prod = (CW+DimW)'(b_qy) * (CW+DimW)'(DIM);
    base_x  = b_x - mx_prod[CW-1:0];
    base_y  = b_y - my_prod[CW-1:0];
    sum_x   = DimW'(base_x) + DimW'(cnt[1:0]);
    sum_y   = DimW'(base_y) + DimW'(cnt[3:2]);
    pix_x   = (sum_x >= DIM) ? (sum_x - DIM) : sum_x;
    pix_y   = (sum_y >= DIM) ? (sum_y - DIM) : sum_y;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {pix_y[CW-1:0], pix_x[CW-1:0], b_tab.alpha[ai],
                  b_tab.rgb[ci][2], b_tab.rgb[ci][1], b_tab.rgb[ci][0]};
      m_tlast <= (cnt == 4'(bc13_pkg::PixCount - 1));
    end
  end

  // Checks
  a_cnt_in_block: assert property (@(posedge clk) disable iff (rst)
    (cnt != 4'd0) |-> b_valid)
    else $error("pixel counter running without a loaded block");

  a_wrap_after_last: assert property (@(posedge clk) disable iff (rst)
    b_done |=> (cnt == 4'd0))
    else $error("pixel counter did not wrap after the last pixel");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !a_valid |-> s_tready)
    else $error("input not ready with an empty input register");

  a_last_from_emit: assert property (@(posedge clk) disable iff (rst)
    b_done |=> (m_tvalid && m_tlast))
    else $error("last pixel of a block not flagged on the output");

  a_reset_bc1: assert property (@(posedge clk)
    $past(rst) && !$past(cfg_valid) |-> !format_bc3)
    else $error("format not BC1 after reset");

endmodule

[hdl/bc13_table.sv]
// Builds the colour palette and alpha table of one compressed block.
// Pure combinational; depends on bc13_pkg for bc13_tab_t and the
// expansion and constant-division helpers.
module bc13_table (
  input  logic               format_bc3,
  input  logic [31:0]        colour_ends,  // c0 in [15:0], c1 in [31:16]
  input  logic [15:0]        alpha_ends,   // a0 in [7:0], a1 in [15:8]
  output bc13_pkg::bc13_tab_t tab
);

  logic [2:0][7:0] e0;
  logic [2:0][7:0] e1;
  logic [7:0]      a0;
  logic [7:0]      a1;

  // Endpoint expansion from RGB565
  always_comb begin
    e0[0] = bc13_pkg::expand5(colour_ends[15:11]);
    e0[1] = bc13_pkg::expand6(colour_ends[10:5]);
    e0[2] = bc13_pkg::expand5(colour_ends[4:0]);
    e1[0] = bc13_pkg::expand5(colour_ends[31:27]);
    e1[1] = bc13_pkg::expand6(colour_ends[26:21]);
    e1[2] = bc13_pkg::expand5(colour_ends[20:16]);
    a0    = alpha_ends[7:0];
    a1    = alpha_ends[15:8];
  end

  always_comb begin
    // Four-colour palette, thirds always used
    for (int k = 0; k < 3; k++) begin
      tab.rgb[0][k] = e0[k];
      tab.rgb[1][k] = e1[k];
      tab.rgb[2][k] = bc13_pkg::div3({1'b0, e0[k], 1'b0} + {2'b00, e1[k]});
      tab.rgb[3][k] = bc13_pkg::div3({2'b00, e0[k]} + {1'b0, e1[k], 1'b0});
    end

    // Alpha table: sevenths when a0 > a1, else fifths plus 0 and 255.
    // BC1 blocks are fully opaque.
    tab.alpha = '0;
    if (!format_bc3) begin
      for (int k = 0; k < 8; k++) begin
        tab.alpha[k] = 8'hFF;
      end
    end else begin
      tab.alpha[0] = a0;
      tab.alpha[1] = a1;
      if (a0 > a1) begin
        for (int k = 1; k <= 6; k++) begin
          tab.alpha[1 + k] = bc13_pkg::div7(11'((7 - k) * int'(a0) + k * int'(a1)));
        end
      end else begin
        for (int k = 1; k <= 4; k++) begin
          tab.alpha[1 + k] = bc13_pkg::div5(11'((5 - k) * int'(a0) + k * int'(a1)));
        end
        tab.alpha[6] = 8'h00;
        tab.alpha[7] = 8'hFF;
      end
    end
  end

endmodule
